### rtl/utcc_pkg.sv
package utcc_pkg;

    localparam int SECS_W = 38;
    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned EPOCH_SHIFT   = 719468;
    localparam int unsigned DAYS_PER_ERA  = 146097;
    localparam int unsigned LAST_ERA_DAY  = 146096;
    localparam int unsigned DAYS_PER_CENT = 36524;
    localparam int unsigned DAYS_PER_4Y   = 1460;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned YEARS_PER_ERA = 400;
    localparam int unsigned YEAR_MIN      = 1970;
    localparam int unsigned YEAR_MAX      = 9999;
    localparam int unsigned MONTHS        = 12;
    localparam int unsigned HOUR_MAX      = 23;
    localparam int unsigned MIN_MAX       = 59;

    // The day count is taken as (seconds >> DAY_SHIFT) / DAY_DIV_LOW.
    localparam int unsigned DAY_SHIFT   = 7;
    localparam int unsigned DAY_DIV_LOW = SECS_PER_DAY >> DAY_SHIFT;

    localparam logic [SECS_W-1:0] MAX_SECONDS = 38'd253402300799;

    localparam logic KIND_TO_CIVIL = 1'b0;
    localparam logic KIND_TO_SECS  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [SECS_W-1:0] unix_seconds;
        logic [YEAR_W-1:0] year_in;
        logic [MON_W-1:0]  month_in;
        logic [DAY_W-1:0]  day_in;
        logic [HOUR_W-1:0] hour_in;
        logic [MIN_W-1:0]  minute_in;
        logic [SEC_W-1:0]  sec_in;
    } t_in;

    typedef struct packed {
        logic [SECS_W-1:0] unix_seconds_out;
        logic [YEAR_W-1:0] year_out;
        logic [MON_W-1:0]  month_out;
        logic [DAY_W-1:0]  day_out;
        logic [HOUR_W-1:0] hour_out;
        logic [MIN_W-1:0]  minute_out;
        logic [SEC_W-1:0]  sec_out;
        logic              range_error;
    } t_out;

    // First day of each month within a March-based year.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        unique case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/utcc_cdiv.sv
module utcc_cdiv #(
    parameter int          W   = 17,
    parameter int unsigned DIV = 60
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_x,
    output logic [W-1:0] o_q,
    output logic [W-1:0] o_r
);

    // Truncated reciprocal: the estimate is never high and at most one low.
    localparam longint unsigned RECIP_FULL = (64'd1 << W) / DIV;
    localparam logic [W-1:0]    RECIP      = W'(RECIP_FULL);
    localparam logic [W-1:0]    DIVISOR    = W'(DIV);

    logic [2*W-1:0] w_prod;
    logic [2*W-1:0] w_back;
    logic [W-1:0]   w_rem;
    logic           w_fix;

    logic [W-1:0] r_x;
    logic [W-1:0] r_qe;
    logic [W-1:0] r_q;
    logic [W-1:0] r_r;
    logic [W-1:0] n_q;
    logic [W-1:0] n_r;

    assign w_prod = {{W{1'b0}}, i_x} * {{W{1'b0}}, RECIP};
    assign w_back = {{W{1'b0}}, r_qe} * {{W{1'b0}}, DIVISOR};
    assign w_rem  = r_x - w_back[W-1:0];
    assign w_fix  = (w_rem >= DIVISOR);
    assign n_q    = w_fix ? r_qe + W'(1) : r_qe;
    assign n_r    = w_fix ? w_rem - DIVISOR : w_rem;

    always_ff @(posedge i_clk) begin
        r_x  <= i_x;
        r_qe <= w_prod[2*W-1:W];
        r_q  <= n_q;
        r_r  <= n_r;
    end

    assign o_q = r_q;
    assign o_r = r_r;

endmodule

### rtl/unix_time_civil_converter_unit.sv
// Throughput: one item per cycle; busy stays low, since every stage advances every cycle.
// The pipeline holds a chain of reciprocal-multiply dividers on the seconds-to-date path.
// Results are strobed by o_done for one cycle and cannot be held off by the receiver.
// Reset (synchronous, active low) clears the valid pipeline and o_done; items in flight are lost.
module unix_time_civil_converter_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  utcc_pkg::t_in   i_item,
    output logic            o_busy,
    output logic            o_done,
    output utcc_pkg::t_out  o_result
);
    import utcc_pkg::*;

    localparam int NS = 13;

    localparam int W_D675 = SECS_W - DAY_SHIFT;
    localparam int W_D400 = YEAR_W;
    localparam int W_TOD  = 17;
    localparam int W_ERA  = 22;
    localparam int W_TMIN = 11;
    localparam int W_DOE  = 18;

    typedef struct packed {
        logic              kind;
        logic [SECS_W-1:0] secs;
        logic [YEAR_W-1:0] y_in;
        logic [MON_W-1:0]  m_in;
        logic [DAY_W-1:0]  d_in;
        logic [HOUR_W-1:0] h_in;
        logic [MIN_W-1:0]  mi_in;
        logic [SEC_W-1:0]  s_in;
        logic              err0;
        logic              bad;
        logic [13:0]       yy;
        logic [3:0]        mp1;
        logic [8:0]        doy1;
        logic [16:0]       tod;
        logic [4:0]        era1;
        logic [17:0]       doe1;
        logic [21:0]       days1;
        logic [SECS_W-1:0] secs1;
        logic [SEC_W-1:0]  tsec;
        logic [HOUR_W-1:0] hr;
        logic [MIN_W-1:0]  mn;
        logic [4:0]        era0;
        logic [17:0]       doe0;
        logic [2:0]        c_cent;
        logic              last_day;
        logic [8:0]        yoe0;
        logic [17:0]       t_yr;
        logic [8:0]        doy0;
        logic [3:0]        mp0;
        logic [YEAR_W-1:0] y0;
        logic [MON_W-1:0]  m0;
        logic [DAY_W-1:0]  d0;
    } t_pipe;

    function automatic logic [1:0] cent_of(input logic [8:0] yoe);
        return 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
    endfunction

    logic            w_accept;
    logic [NS-1:0]   r_vld;
    logic            r_done;
    t_pipe           r_p [NS];
    t_pipe           n_p [NS];
    t_out            r_res;
    t_out            n_res;

    logic [W_D675-1:0] d675_q, d675_r;
    logic [W_D400-1:0] d400_q, d400_r;
    logic [W_TOD-1:0]  dsec_q, dsec_r;
    logic [W_ERA-1:0]  dera_q, dera_r;
    logic [W_TMIN-1:0] dmin_q, dmin_r;
    logic [W_DOE-1:0]  d4y_q, d4y_r;
    logic [W_DOE-1:0]  dyr_q, dyr_r;

    logic [W_TOD-1:0]  w_rem;
    logic [W_ERA-1:0]  w_z;
    logic [W_DOE-1:0]  w_n;

    assign o_busy   = 1'b0;
    assign w_accept = i_start & ~o_busy;

    // Day count and remainder: the low seven bits bypass the divide by 675.
    utcc_cdiv #(.W(W_D675), .DIV(DAY_DIV_LOW)) u_div_day (
        .i_clk (i_clk),
        .i_x   (r_p[0].secs[SECS_W-1:DAY_SHIFT]),
        .o_q   (d675_q),
        .o_r   (d675_r)
    );

    utcc_cdiv #(.W(W_D400), .DIV(YEARS_PER_ERA)) u_div_era_yr (
        .i_clk (i_clk),
        .i_x   (r_p[1].yy),
        .o_q   (d400_q),
        .o_r   (d400_r)
    );

    assign w_rem = {d675_r[9:0], r_p[2].secs[DAY_SHIFT-1:0]};
    assign w_z   = d675_q[W_ERA-1:0] + W_ERA'(EPOCH_SHIFT);

    utcc_cdiv #(.W(W_TOD), .DIV(SECS_PER_MIN)) u_div_sec (
        .i_clk (i_clk),
        .i_x   (w_rem),
        .o_q   (dsec_q),
        .o_r   (dsec_r)
    );

    utcc_cdiv #(.W(W_ERA), .DIV(DAYS_PER_ERA)) u_div_era (
        .i_clk (i_clk),
        .i_x   (w_z),
        .o_q   (dera_q),
        .o_r   (dera_r)
    );

    utcc_cdiv #(.W(W_TMIN), .DIV(SECS_PER_MIN)) u_div_min (
        .i_clk (i_clk),
        .i_x   (dsec_q[W_TMIN-1:0]),
        .o_q   (dmin_q),
        .o_r   (dmin_r)
    );

    utcc_cdiv #(.W(W_DOE), .DIV(DAYS_PER_4Y)) u_div_4y (
        .i_clk (i_clk),
        .i_x   (dera_r[W_DOE-1:0]),
        .o_q   (d4y_q),
        .o_r   (d4y_r)
    );

    // Leap-corrected day of era, divided by 365 to give the year of era.
    assign w_n = r_p[6].doe0 - d4y_q + W_DOE'(r_p[6].c_cent) - W_DOE'(r_p[6].last_day);

    utcc_cdiv #(.W(W_DOE), .DIV(DAYS_PER_YEAR)) u_div_yr (
        .i_clk (i_clk),
        .i_x   (w_n),
        .o_q   (dyr_q),
        .o_r   (dyr_r)
    );

    always_comb begin
        logic [3:0] v_mp;
        logic [3:0] v_m;
        v_mp = '0;
        v_m  = r_p[11].mp0;

        n_p[0]              = '0;
        n_p[0].kind         = i_item.kind;
        n_p[0].secs         = i_item.unix_seconds;
        n_p[0].y_in         = i_item.year_in;
        n_p[0].m_in         = i_item.month_in;
        n_p[0].d_in         = i_item.day_in;
        n_p[0].h_in         = i_item.hour_in;
        n_p[0].mi_in        = i_item.minute_in;
        n_p[0].s_in         = i_item.sec_in;

        for (int k = 1; k < NS; k++) begin
            n_p[k] = r_p[k-1];
        end

        n_p[1].err0 = (r_p[0].secs > MAX_SECONDS);
        n_p[1].bad  = (r_p[0].y_in < YEAR_W'(YEAR_MIN)) || (r_p[0].y_in > YEAR_W'(YEAR_MAX)) ||
                      (r_p[0].m_in == 4'd0) || (r_p[0].m_in > MON_W'(MONTHS)) ||
                      (r_p[0].d_in == 5'd0) || (r_p[0].h_in > HOUR_W'(HOUR_MAX)) ||
                      (r_p[0].mi_in > MIN_W'(MIN_MAX)) || (r_p[0].s_in > SEC_W'(MIN_MAX));
        n_p[1].yy   = r_p[0].y_in - YEAR_W'(r_p[0].m_in <= 4'd2);
        n_p[1].mp1  = (r_p[0].m_in > 4'd2) ? r_p[0].m_in - 4'd3 : r_p[0].m_in + 4'd9;
        n_p[1].doy1 = month_start(n_p[1].mp1) + 9'(r_p[0].d_in) - 9'd1;

        n_p[2].tod = 17'(r_p[1].h_in) * 17'(SECS_PER_HOUR) +
                     17'(r_p[1].mi_in) * 17'(SECS_PER_MIN) + 17'(r_p[1].s_in);

        n_p[4].era1 = d400_q[4:0];
        n_p[4].doe1 = 18'(d400_r[8:0]) * 18'(DAYS_PER_YEAR) + 18'(d400_r[8:2]) -
                      18'(cent_of(d400_r[8:0])) + 18'(r_p[3].doy1);

        n_p[5].days1    = 22'(r_p[4].era1) * 22'(DAYS_PER_ERA) + 22'(r_p[4].doe1) -
                          22'(EPOCH_SHIFT);
        n_p[5].tsec     = dsec_r[SEC_W-1:0];
        n_p[5].era0     = dera_q[4:0];
        n_p[5].doe0     = dera_r[W_DOE-1:0];
        n_p[5].c_cent   = 3'(dera_r >= W_ERA'(DAYS_PER_CENT)) +
                          3'(dera_r >= W_ERA'(2 * DAYS_PER_CENT)) +
                          3'(dera_r >= W_ERA'(3 * DAYS_PER_CENT)) +
                          3'(dera_r >= W_ERA'(4 * DAYS_PER_CENT));
        n_p[5].last_day = (dera_r == W_ERA'(LAST_ERA_DAY));

        n_p[6].secs1 = SECS_W'(r_p[5].days1) * SECS_W'(SECS_PER_DAY) + SECS_W'(r_p[5].tod);

        n_p[7].hr = dmin_q[HOUR_W-1:0];
        n_p[7].mn = dmin_r[MIN_W-1:0];

        n_p[9].yoe0 = dyr_q[8:0];
        n_p[9].t_yr = 18'(dyr_q[8:0]) * 18'(DAYS_PER_YEAR) + 18'(dyr_q[8:2]) -
                      18'(cent_of(dyr_q[8:0]));

        n_p[10].doy0 = 9'(r_p[9].doe0 - r_p[9].t_yr);

        for (int j = 1; j < 12; j++) begin
            v_mp = v_mp + 4'(r_p[10].doy0 >= month_start(4'(j)));
        end
        n_p[11].mp0 = v_mp;

        // January and February belong to the following calendar year.
        n_p[12].m0 = (v_m < 4'd10) ? v_m + 4'd3 : v_m - 4'd9;
        n_p[12].d0 = 5'(r_p[11].doy0 - month_start(v_m) + 9'd1);
        n_p[12].y0 = 14'(r_p[11].yoe0) + 14'(r_p[11].era0) * 14'(YEARS_PER_ERA) +
                     14'(v_m >= 4'd10);
    end

    always_comb begin
        n_res = '0;
        if (r_p[NS-1].kind == KIND_TO_CIVIL) begin
            if (r_p[NS-1].err0) begin
                n_res.range_error = 1'b1;
            end else begin
                n_res.unix_seconds_out = r_p[NS-1].secs;
                n_res.year_out         = r_p[NS-1].y0;
                n_res.month_out        = r_p[NS-1].m0;
                n_res.day_out          = r_p[NS-1].d0;
                n_res.hour_out         = r_p[NS-1].hr;
                n_res.minute_out       = r_p[NS-1].mn;
                n_res.sec_out          = r_p[NS-1].tsec;
            end
        end else begin
            if (r_p[NS-1].bad) begin
                n_res.range_error = 1'b1;
            end else begin
                n_res.unix_seconds_out = r_p[NS-1].secs1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[NS-2:0], w_accept};
            r_done <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            r_p[k] <= n_p[k];
        end
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##(NS + 1) o_done)
        else $error("accepted item did not produce a result on time");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, NS + 1))
        else $error("result strobe without an accepted item");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.range_error) |->
        (o_result.unix_seconds_out == '0 && o_result.year_out == '0 &&
         o_result.month_out == '0 && o_result.day_out == '0 && o_result.hour_out == '0 &&
         o_result.minute_out == '0 && o_result.sec_out == '0))
        else $error("range error with nonzero result fields");

    a_civil_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.range_error && o_result.year_out != '0) |->
        (o_result.month_out >= 4'd1 && o_result.month_out <= 4'd12 &&
         o_result.day_out >= 5'd1 && o_result.hour_out <= 5'd23 &&
         o_result.minute_out <= 6'd59 && o_result.sec_out <= 6'd59))
        else $error("date fields out of range");

    a_secs_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.range_error && o_result.year_out == '0) |->
        (o_result.month_out == '0 && o_result.day_out == '0 && o_result.hour_out == '0))
        else $error("seconds result with stray date fields");

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
    import utcc_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int LATENCY      = 13;
    localparam int RANDOM_ITEMS = 1450;
    localparam int STALL_LIMIT  = 2000;
    localparam int IDLE_PCT     = 36;
    localparam int STEADY_FIRST = 500;
    localparam int STEADY_LAST  = 800;

    typedef struct {
        t_in item;
        bit  drain_first;
    } t_request;

    logic   i_clk;
    logic   i_rst_n = 1'b0;
    logic   i_start = 1'b0;
    t_in    i_item  = '0;
    logic   o_busy;
    logic   o_done;
    t_out   o_result;

    t_request conversion_requests[$];
    t_out     predicted_results[$];
    int       n_sent = 0;
    int       n_recv = 0;
    int       n_errors = 0;
    int       stall_cycles = 0;

    unix_time_civil_converter_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_out predict_conversion(t_in it);
        t_out r;
        longint unsigned secs, days, rem, z, era, doe, yoe, doy, mp, d, m, y, yy;
        longint unsigned h, mi, s;
        r = '0;
        if (it.kind == KIND_TO_CIVIL) begin
            secs = 64'(it.unix_seconds);
            if (it.unix_seconds > MAX_SECONDS) begin
                r.range_error = 1'b1;
            end else begin
                days = secs / 86400;
                rem  = secs % 86400;
                z    = days + 719468;
                era  = z / 146097;
                doe  = z - era * 146097;
                yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
                doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
                mp   = (5 * doy + 2) / 153;
                d    = doy - (153 * mp + 2) / 5 + 1;
                m    = (mp < 10) ? mp + 3 : mp - 9;
                y    = yoe + era * 400 + ((m <= 2) ? 1 : 0);
                r.unix_seconds_out = it.unix_seconds;
                r.year_out   = YEAR_W'(y);
                r.month_out  = MON_W'(m);
                r.day_out    = DAY_W'(d);
                r.hour_out   = HOUR_W'(rem / 3600);
                r.minute_out = MIN_W'((rem % 3600) / 60);
                r.sec_out    = SEC_W'(rem % 60);
            end
        end else begin
            y  = 64'(it.year_in);
            m  = 64'(it.month_in);
            d  = 64'(it.day_in);
            h  = 64'(it.hour_in);
            mi = 64'(it.minute_in);
            s  = 64'(it.sec_in);
            if (y < YEAR_MIN || y > YEAR_MAX || m < 1 || m > 12 || d < 1 ||
                h > 23 || mi > 59 || s > 59) begin
                r.range_error = 1'b1;
            end else begin
                // The internal year starts in March, so January and February
                // belong to the previous year.
                yy   = y - ((m <= 2) ? 1 : 0);
                era  = yy / 400;
                yoe  = yy - era * 400;
                mp   = (m > 2) ? m - 3 : m + 9;
                doy  = (153 * mp + 2) / 5 + d - 1;
                doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
                days = era * 146097 + doe - 719468;
                r.unix_seconds_out = SECS_W'(days * 86400 + h * 3600 + mi * 60 + s);
            end
        end
        return r;
    endfunction

    function automatic logic [SECS_W-1:0] rand_secs();
        return SECS_W'({$urandom(), $urandom()});
    endfunction

    // Unused fields carry random content, since the block must ignore them.
    function automatic t_in mk_to_civil(longint unsigned secs);
        t_in it;
        it = t_in'({$urandom(), $urandom(), $urandom()});
        it.kind = KIND_TO_CIVIL;
        it.unix_seconds = SECS_W'(secs);
        return it;
    endfunction

    function automatic t_in mk_to_secs(int y, int m, int d, int h, int mi, int s);
        t_in it;
        it = t_in'({$urandom(), $urandom(), $urandom()});
        it.kind      = KIND_TO_SECS;
        it.year_in   = YEAR_W'(y);
        it.month_in  = MON_W'(m);
        it.day_in    = DAY_W'(d);
        it.hour_in   = HOUR_W'(h);
        it.minute_in = MIN_W'(mi);
        it.sec_in    = SEC_W'(s);
        return it;
    endfunction

    function automatic t_in make_random_request();
        t_in it;
        int  r;
        r = $urandom_range(0, 99);
        if (r < 38) begin
            it = mk_to_civil(64'(rand_secs()) % (64'(MAX_SECONDS) + 64'd1));
        end else if (r < 43) begin
            it = mk_to_civil(64'(rand_secs()));
        end else if (r < 47) begin
            it = mk_to_civil(64'(MAX_SECONDS) - 64 + $urandom_range(0, 128));
        end else if (r < 58) begin
            it = t_in'({$urandom(), $urandom(), $urandom()});
            it.kind = KIND_TO_SECS;
        end else begin
            it = mk_to_secs($urandom_range(YEAR_MIN, YEAR_MAX), $urandom_range(1, 12),
                            $urandom_range(1, 31), $urandom_range(0, 23),
                            $urandom_range(0, 59), $urandom_range(0, 59));
            if (r < 62) begin
                it.year_in = YEAR_W'(($urandom_range(0, 1)) ? YEAR_MIN : YEAR_MAX);
            end else if (r < 72) begin
                // Break exactly one field of an otherwise valid date.
                case ($urandom_range(0, 5))
                    0: it.year_in = YEAR_W'(($urandom_range(0, 1))
                                            ? $urandom_range(0, YEAR_MIN - 1)
                                            : $urandom_range(YEAR_MAX + 1, 16383));
                    1: it.month_in = ($urandom_range(0, 1)) ? 4'd0
                                                            : MON_W'($urandom_range(13, 15));
                    2: it.day_in = '0;
                    3: it.hour_in = HOUR_W'($urandom_range(24, 31));
                    4: it.minute_in = MIN_W'($urandom_range(60, 63));
                    default: it.sec_in = SEC_W'($urandom_range(60, 63));
                endcase
            end
        end
        return it;
    endfunction

    task automatic add_request(t_in it, bit drain_first);
        t_request req;
        req.item = it;
        req.drain_first = drain_first;
        conversion_requests.push_back(req);
    endtask

    task automatic log_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic compare_result(t_out got, t_out want);
        if (got.unix_seconds_out !== want.unix_seconds_out)
            log_mismatch($sformatf("unix_seconds_out %0d, want %0d",
                                   got.unix_seconds_out, want.unix_seconds_out));
        if (got.year_out !== want.year_out)
            log_mismatch($sformatf("year_out %0d, want %0d", got.year_out, want.year_out));
        if (got.month_out !== want.month_out)
            log_mismatch($sformatf("month_out %0d, want %0d", got.month_out, want.month_out));
        if (got.day_out !== want.day_out)
            log_mismatch($sformatf("day_out %0d, want %0d", got.day_out, want.day_out));
        if (got.hour_out !== want.hour_out)
            log_mismatch($sformatf("hour_out %0d, want %0d", got.hour_out, want.hour_out));
        if (got.minute_out !== want.minute_out)
            log_mismatch($sformatf("minute_out %0d, want %0d",
                                   got.minute_out, want.minute_out));
        if (got.sec_out !== want.sec_out)
            log_mismatch($sformatf("sec_out %0d, want %0d", got.sec_out, want.sec_out));
        if (got.range_error !== want.range_error)
            log_mismatch($sformatf("range_error %0b, want %0b",
                                   got.range_error, want.range_error));
    endtask

    always @(posedge i_clk) begin : driver
        bit       accepted;
        bit       idle;
        t_request req;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            accepted = i_start && !o_busy;
            if (accepted) begin
                predicted_results.push_back(predict_conversion(i_item));
                n_sent++;
            end
            if (!i_start || accepted) begin
                idle = (n_sent < STEADY_FIRST || n_sent >= STEADY_LAST) &&
                       ($urandom_range(0, 99) < IDLE_PCT);
                if (conversion_requests.size() == 0 || idle ||
                    (conversion_requests[0].drain_first && n_sent != n_recv)) begin
                    i_start <= 1'b0;
                end else begin
                    req = conversion_requests.pop_front();
                    i_item  <= req.item;
                    i_start <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (i_rst_n && o_done) begin
            if (predicted_results.size() == 0) begin
                log_mismatch("result with no item outstanding");
            end else begin
                want = predicted_results.pop_front();
                compare_result(o_result, want);
                n_recv <= n_recv + 1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        // Epoch neighborhood, leap days, the last valid second and beyond.
        add_request(mk_to_civil(64'd0), 1'b0);
        add_request(mk_to_civil(64'd1), 1'b0);
        add_request(mk_to_civil(64'd86399), 1'b0);
        add_request(mk_to_civil(64'd86400), 1'b0);
        add_request(mk_to_civil(64'd951782400), 1'b0);
        add_request(mk_to_civil(64'd951868800), 1'b0);
        add_request(mk_to_civil(64'd2147483648), 1'b0);
        add_request(mk_to_civil(64'(MAX_SECONDS)), 1'b0);
        add_request(mk_to_civil(64'(MAX_SECONDS) + 64'd1), 1'b0);
        add_request(mk_to_civil(64'h3F_FFFF_FFFF), 1'b0);
        add_request(mk_to_secs(1970, 1, 1, 0, 0, 0), 1'b0);
        add_request(mk_to_secs(9999, 12, 31, 23, 59, 59), 1'b0);
        add_request(mk_to_secs(2000, 2, 29, 12, 30, 30), 1'b0);
        // Days past the end of a short month roll into the next month.
        add_request(mk_to_secs(2023, 2, 31, 0, 0, 0), 1'b0);
        add_request(mk_to_secs(2100, 2, 29, 6, 7, 8), 1'b0);
        add_request(mk_to_secs(1969, 12, 31, 23, 59, 59), 1'b0);
        add_request(mk_to_secs(10000, 1, 1, 0, 0, 0), 1'b0);
        add_request(mk_to_secs(16383, 15, 31, 31, 63, 63), 1'b0);
        add_request(mk_to_secs(0, 0, 0, 0, 0, 0), 1'b0);
        add_request(mk_to_secs(2000, 0, 1, 0, 0, 0), 1'b0);
        add_request(mk_to_secs(2000, 13, 1, 0, 0, 0), 1'b0);
        add_request(mk_to_secs(2000, 5, 0, 0, 0, 0), 1'b0);
        add_request(mk_to_secs(2000, 5, 1, 24, 0, 0), 1'b0);
        add_request(mk_to_secs(2000, 5, 1, 0, 60, 0), 1'b0);
        add_request(mk_to_secs(2000, 5, 1, 0, 0, 60), 1'b0);
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            add_request(make_random_request(), k == 0 || k == 600 || k == 1200);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (conversion_requests.size() != 0 || i_start) @(negedge i_clk);
        while (n_recv != n_sent) @(negedge i_clk);
        repeat (2 * LATENCY) @(negedge i_clk);

        if (predicted_results.size() != 0) begin
            log_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
        end
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
